// ----- src/mmff_pkg.sv -----
// Package for the MIDI message framer and filter: status codes, class bits,
// controller state type and the command/status structs between its modules.
// No dependencies.
package mmff_pkg;

    // Status bytes and masks used when framing.
    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [3:0] HI_NOTE_OFF    = 4'h8;
    localparam logic [3:0] HI_NOTE_ON     = 4'h9;
    localparam logic [3:0] HI_CTRL_CHANGE = 4'hB;
    localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;
    localparam logic [3:0] HI_PITCH_BEND  = 4'hE;
    localparam logic [7:0] CC_MOD_WHEEL   = 8'h01;

    // Message class bits, shared by both filter masks.
    localparam logic [3:0] CLS_NOTE  = 4'b0001;
    localparam logic [3:0] CLS_PRESS = 4'b0010;
    localparam logic [3:0] CLS_PITCH = 4'b0100;
    localparam logic [3:0] CLS_MOD   = 4'b1000;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_MASK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCARD_MASK = 2'd1;
    localparam int unsigned CFG_DATA_W = 4;

    localparam int unsigned DEF_BUF_DEPTH = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHOW
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic take;     // consume the input byte
        logic load;     // read one stored byte into the output register
        logic advance;  // step to the next stored byte
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic emit_req; // the byte on the input completes a message to emit
        logic last;     // output register holds the final byte
    } dp_stat_t;

    // Expected length of a channel message, zero for unsupported status.
    function automatic logic [1:0] channel_length(input logic [7:0] status);
        logic [1:0] len;
        begin
            case (status[7:4])
                HI_NOTE_OFF, HI_NOTE_ON, HI_CTRL_CHANGE, HI_PITCH_BEND: len = 2'd3;
                HI_CHAN_PRESS: len = 2'd2;
                default: len = 2'd0;
            endcase
            return len;
        end
    endfunction

endpackage

// ----- src/midi_message_framer_filter.sv -----
// Top level of the MIDI message framer and filter.
// Depends on mmff_pkg, mmff_datapath and mmff_ctrl.
//
// Usage:
//   Raw MIDI bytes enter on the s_ channel (s_valid/s_ready, s_midi_byte).
//   Note on/off, control change, channel pressure, pitch bend and SysEx are
//   framed; other bytes are dropped. A completed message is classed and,
//   under echo_mask and discard_mask, echoed, discarded or delivered.
//   Bytes of an emitted message leave on the m_ channel, one per
//   transaction, each with m_destination, and m_last_of_message set on the
//   final byte.
//   The masks are written through cfg_valid/cfg_index/cfg_data; the user must
//   write them while idle, which the block itself does not enforce; cfg_ready is always high.
// Operation:
//   A byte that completes no message leaves the block idle, ready for the
//   next byte. A completed message is read from the buffer memory byte by
//   byte, each read into the output register and then shown until accepted;
//   no input is taken until its last byte is accepted.
//   A stalled receiver holds the output register and freezes the block.
// Reset:
//   aresetn (synchronous, active low) clears both masks and any partial
//   message. The buffer needs no clearing pass.
module midi_message_framer_filter
    import mmff_pkg::*;
#(
    parameter int unsigned BUF_DEPTH = DEF_BUF_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_midi_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_destination,
    output logic                  m_last_of_message,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    mmff_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mmff_datapath #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .midi_byte       (s_midi_byte),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .stat            (stat),
        .out_byte        (m_out_byte),
        .destination     (m_destination),
        .last_of_message (m_last_of_message)
    );

endmodule

// ----- src/mmff_datapath.sv -----
// Datapath of the MIDI message framer and filter: framing registers,
// message buffer, classification, filter masks and the output register.
// Depends on mmff_pkg.
module mmff_datapath
    import mmff_pkg::*;
#(
    parameter int unsigned BUF_DEPTH = DEF_BUF_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0]            midi_byte,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    output logic [7:0]            out_byte,
    output logic                  destination,
    output logic                  last_of_message
);

    localparam int unsigned AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int unsigned CW = $clog2(BUF_DEPTH + 1);

    logic [7:0]    mem [BUF_DEPTH];

    logic [3:0]    echo_mask_reg, discard_mask_reg;
    logic [CW-1:0] fill_reg, fill_next;
    logic [1:0]    explen_reg, explen_next;
    logic          ovf_reg, ovf_next;
    logic [7:0]    status_reg, status_next;
    logic [7:0]    data1_reg;
    logic [CW-1:0] emit_len_reg, emit_len_next;
    logic          dest_reg, dest_next;
    logic [AW-1:0] idx_reg;
    logic [7:0]    out_byte_reg;
    logic          last_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          in_sysex, room, do_finish, emit;
    logic [7:0]    data1;
    logic [3:0]    cls;

    assign in_sysex = (fill_reg != '0) && (status_reg == ST_SYSEX_START);
    assign room     = fill_reg < CW'(BUF_DEPTH);
    assign data1    = (fill_reg == CW'(1)) ? midi_byte : data1_reg;

    // Class of the message that completes on this byte.
    always_comb begin
        cls = '0;
        case (status_reg[7:4])
            HI_NOTE_OFF, HI_NOTE_ON: cls = CLS_NOTE;
            HI_CHAN_PRESS:           cls = CLS_PRESS;
            HI_PITCH_BEND:           cls = CLS_PITCH;
            HI_CTRL_CHANGE:          cls = (data1 == CC_MOD_WHEEL) ? CLS_MOD : '0;
            default:                 cls = '0;
        endcase
        if (status_reg == ST_SYSEX_START) begin
            cls = '0;
        end
    end

    // Framing: next state of the message registers for the input byte.
    always_comb begin
        fill_next     = fill_reg;
        explen_next   = explen_reg;
        ovf_next      = ovf_reg;
        status_next   = status_reg;
        wr_en         = 1'b0;
        wr_addr       = fill_reg[AW-1:0];
        do_finish     = 1'b0;
        emit          = 1'b0;
        dest_next     = 1'b0;
        emit_len_next = fill_reg + CW'(1);
        if (midi_byte[7]) begin
            if (in_sysex && (midi_byte == ST_SYSEX_END)) begin
                wr_en = room;
                if (room && !ovf_reg) begin
                    do_finish = 1'b1;
                end
                fill_next   = '0;
                explen_next = '0;
                ovf_next    = 1'b0;
            end else begin
                // New status drops any partial message.
                ovf_next    = 1'b0;
                wr_addr     = '0;
                status_next = midi_byte;
                explen_next = channel_length(midi_byte);
                if (midi_byte == ST_SYSEX_START) begin
                    explen_next = '0;
                    fill_next   = CW'(1);
                    wr_en       = 1'b1;
                end else if (channel_length(midi_byte) != 2'd0) begin
                    fill_next = CW'(1);
                    wr_en     = 1'b1;
                end else begin
                    fill_next = '0;
                end
            end
        end else if (fill_reg != '0) begin
            if (in_sysex) begin
                wr_en = room;
                if (room) begin
                    fill_next = fill_reg + CW'(1);
                end else begin
                    ovf_next = 1'b1;
                end
            end else if (explen_reg != 2'd0) begin
                wr_en = 1'b1;
                if ((fill_reg + CW'(1)) >= CW'(explen_reg)) begin
                    do_finish   = 1'b1;
                    fill_next   = '0;
                    explen_next = '0;
                    ovf_next    = 1'b0;
                end else begin
                    fill_next = fill_reg + CW'(1);
                end
            end
        end
        // Filter: echo wins over discard.
        if (do_finish) begin
            if ((echo_mask_reg & cls) != '0) begin
                emit      = 1'b1;
                dest_next = 1'b1;
            end else if ((discard_mask_reg & cls) == '0) begin
                emit = 1'b1;
            end
        end
    end

    assign stat.emit_req = emit;
    assign stat.last     = last_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_mask_reg    <= '0;
            discard_mask_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ECHO_MASK:    echo_mask_reg    <= cfg_data;
                CFG_DISCARD_MASK: discard_mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Framing registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            explen_reg <= '0;
            ovf_reg    <= 1'b0;
            idx_reg    <= '0;
        end else begin
            if (cmd.take) begin
                fill_reg   <= fill_next;
                explen_reg <= explen_next;
                ovf_reg    <= ovf_next;
            end
            if (cmd.take && emit) begin
                idx_reg <= '0;
            end else if (cmd.advance) begin
                idx_reg <= idx_reg + AW'(1);
            end
        end
    end

    // Payload registers without reset.
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            status_reg <= status_next;
            if (!midi_byte[7] && (fill_reg == CW'(1))) begin
                data1_reg <= midi_byte;
            end
            if (emit) begin
                emit_len_reg <= emit_len_next;
                dest_reg     <= dest_next;
            end
        end
        if (cmd.take && wr_en) begin
            mem[wr_addr] <= midi_byte;
        end
        if (cmd.load) begin
            out_byte_reg <= mem[idx_reg];
            last_reg     <= (CW'(idx_reg) + CW'(1)) == emit_len_reg;
        end
    end

    assign out_byte        = out_byte_reg;
    assign destination     = dest_reg;
    assign last_of_message = last_reg;

endmodule

// ----- src/mmff_ctrl.sv -----
// Controller of the MIDI message framer and filter: takes input bytes and
// walks the buffer of a completed message out through the output register.
// Depends on mmff_pkg.
module mmff_ctrl
    import mmff_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && stat.emit_req) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_SHOW;
            ST_SHOW: begin
                if (m_ready) begin
                    state_next = stat.last ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            ST_READ: cmd.load = 1'b1;
            ST_SHOW: begin
                m_valid     = 1'b1;
                cmd.advance = m_ready && !stat.last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- verif/mmff_stream_checker.sv -----
// Checker for the MIDI message framer and filter: watches the byte, result and
// register channels, predicts every emitted byte and compares it on arrival.
// Depends on mmff_pkg.
module mmff_stream_checker
    import mmff_pkg::*;
#(
    parameter int unsigned BUF_DEPTH = DEF_BUF_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [7:0]            s_midi_byte,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [7:0]            m_out_byte,
    input  logic                  m_destination,
    input  logic                  m_last_of_message,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned           pending_count,
    output int unsigned           fail_count
);

    // One emitted byte as it should appear on the result channel.
    typedef struct packed {
        logic [7:0] data;
        logic       dest;
        logic       last;
    } midi_beat_t;

    midi_beat_t  expected_beats[$];
    logic [7:0]  msg_buf [BUF_DEPTH];
    int unsigned msg_fill;
    int unsigned msg_len;
    bit          sysex_overflow;
    logic [3:0]  echo_bits;
    logic [3:0]  discard_bits;
    int unsigned mismatches = 0;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at %0t on %s: got %h, expected %h", $time, field, got, want);
        mismatches++;
    endtask

    // Length of a framed channel message from its status byte; zero if not framed.
    function automatic int unsigned frame_length(input logic [7:0] status);
        case (status[7:4])
            HI_NOTE_OFF, HI_NOTE_ON, HI_CTRL_CHANGE, HI_PITCH_BEND: return 3;
            HI_CHAN_PRESS: return 2;
            default: return 0;
        endcase
    endfunction

    task automatic end_message();
        msg_fill = 0;
        msg_len = 0;
        sysex_overflow = 1'b0;
    endtask

    // Bytes past the buffer depth are lost and mark the message as overflowed.
    task automatic store_byte(input logic [7:0] b);
        if (msg_fill < BUF_DEPTH) begin
            msg_buf[msg_fill] = b;
            msg_fill++;
        end else begin
            sysex_overflow = 1'b1;
        end
    endtask

    // Classify the finished message and queue its bytes unless it is discarded.
    task automatic release_message();
        logic [3:0] cls;
        logic       dest;
        bit         keep;
        midi_beat_t beat;
        cls = '0;
        keep = 1'b1;
        dest = 1'b0;
        case (msg_buf[0][7:4])
            HI_NOTE_OFF, HI_NOTE_ON: cls = CLS_NOTE;
            HI_CHAN_PRESS: cls = CLS_PRESS;
            HI_PITCH_BEND: cls = CLS_PITCH;
            HI_CTRL_CHANGE: begin
                if (msg_fill >= 2 && msg_buf[1] == CC_MOD_WHEEL) cls = CLS_MOD;
            end
            default: ;
        endcase
        // Echo wins over discard.
        if ((echo_bits & cls) != 0) begin
            dest = 1'b1;
        end else if ((discard_bits & cls) != 0) begin
            keep = 1'b0;
        end
        if (keep) begin
            for (int k = 0; k < msg_fill; k++) begin
                beat.data = msg_buf[k];
                beat.dest = dest;
                beat.last = (k + 1 == msg_fill);
                expected_beats.push_back(beat);
            end
        end
        end_message();
    endtask

    // Advance the framing state by one received byte.
    task automatic frame_byte(input logic [7:0] b);
        bit in_sysex;
        in_sysex = (msg_fill > 0) && (msg_buf[0] == ST_SYSEX_START);
        if (b[7]) begin
            if (in_sysex && b == ST_SYSEX_END) begin
                store_byte(b);
                if (sysex_overflow) begin
                    end_message();
                end else begin
                    release_message();
                end
            end else begin
                // Any other status drops the partial message and may start a new one.
                end_message();
                if (b == ST_SYSEX_START) begin
                    msg_buf[0] = b;
                    msg_fill = 1;
                end else begin
                    msg_len = frame_length(b);
                    if (msg_len != 0) begin
                        msg_buf[0] = b;
                        msg_fill = 1;
                    end
                end
            end
        end else if (msg_fill != 0) begin
            // Data bytes with no message in progress are dropped.
            if (in_sysex) begin
                store_byte(b);
            end else if (msg_len != 0) begin
                store_byte(b);
                if (msg_fill >= msg_len) release_message();
            end
        end
    endtask

    // Compare one result transaction with the oldest expected byte.
    task automatic check_beat();
        midi_beat_t want;
        if (expected_beats.size() == 0) begin
            report_mismatch("out_byte with nothing expected", m_out_byte, 8'h00);
        end else begin
            want = expected_beats.pop_front();
            if (m_out_byte !== want.data) begin
                report_mismatch("out_byte", m_out_byte, want.data);
            end
            if (m_destination !== want.dest) begin
                report_mismatch("destination", m_destination, want.dest);
            end
            if (m_last_of_message !== want.last) begin
                report_mismatch("last_of_message", m_last_of_message, want.last);
            end
        end
    endtask

    // Sample all three channels at each rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            echo_bits = '0;
            discard_bits = '0;
            end_message();
            expected_beats.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ECHO_MASK: echo_bits = cfg_data;
                    CFG_DISCARD_MASK: discard_bits = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) check_beat();
            if (s_valid && s_ready) frame_byte(s_midi_byte);
        end
        pending_count <= expected_beats.size();
        fail_count <= mismatches;
    end

endmodule

// ----- verif/tb_midi_message_framer_filter.sv -----
// Testbench top for the MIDI message framer and filter: drives bytes, register
// writes and result back-pressure, and gives the verdict.
// Depends on mmff_pkg, midi_message_framer_filter and mmff_stream_checker.
module tb_midi_message_framer_filter;
    import mmff_pkg::*;

    localparam int unsigned MIDI_BUF_DEPTH = DEF_BUF_DEPTH;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned RANDOM_BYTES   = 2;

    // Status groups the block does not frame.
    localparam logic [3:0] HI_POLY_PRESS  = 4'hA;
    localparam logic [3:0] HI_PROG_CHANGE = 4'hC;

    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_COIN,
        PACE_SPARSE,
        PACE_TOGGLE
    } pace_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_midi_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_out_byte;
    logic                  m_destination;
    logic                  m_last_of_message;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned pending_count;
    int unsigned fail_count;
    int unsigned hold_seq = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    bit          steady_send = 1'b0;
    logic [7:0]  midi_stream[$];

    // Opening sequence: every framed kind, then the corner cases of framing.
    logic [7:0] opening_seq [0:31] = '{
        {HI_NOTE_ON, 4'h0}, 8'h3C, 8'h7F,
        {HI_NOTE_OFF, 4'h0}, 8'h00, 8'h00,
        {HI_CTRL_CHANGE, 4'h0}, CC_MOD_WHEEL, 8'h40,
        {HI_CHAN_PRESS, 4'h5}, 8'h7F,
        {HI_PITCH_BEND, 4'hF}, 8'h00, 8'h7F,
        8'h7F,
        ST_SYSEX_START, 8'h55, ST_SYSEX_END,
        {HI_NOTE_ON, 4'h3}, 8'h10, {HI_CTRL_CHANGE, 4'h1}, 8'h05, 8'h00,
        {HI_POLY_PRESS, 4'h0}, 8'h10,
        {HI_PROG_CHANGE, 4'h4},
        ST_SYSEX_START, 8'h01, 8'hF8, 8'h02, ST_SYSEX_END,
        8'hFF
    };

    midi_message_framer_filter #(
        .BUF_DEPTH(MIDI_BUF_DEPTH)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_midi_byte       (s_midi_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_destination     (m_destination),
        .m_last_of_message (m_last_of_message),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    mmff_stream_checker #(
        .BUF_DEPTH(MIDI_BUF_DEPTH)
    ) u_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_midi_byte       (s_midi_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_destination     (m_destination),
        .m_last_of_message (m_last_of_message),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .pending_count     (pending_count),
        .fail_count        (fail_count)
    );

    // Clock with a period of 10.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver back-pressure: random pacing segments, plus a long hold-off on request.
    initial begin : rx_pacing
        pace_t       pace;
        int unsigned span;
        int unsigned seen;
        seen = 0;
        m_ready <= 1'b0;
        forever begin
            pace = pace_t'($urandom_range(3));
            span = $urandom_range(60, 10);
            repeat (span) begin
                @(posedge aclk);
                if (hold_seq != seen) begin
                    seen = hold_seq;
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end
                case (pace)
                    PACE_FREE: m_ready <= 1'b1;
                    PACE_COIN: m_ready <= 1'($urandom_range(1));
                    PACE_SPARSE: m_ready <= ($urandom_range(3) == 0);
                    default: m_ready <= ~m_ready;
                endcase
            end
        end
    end

    // Write both masks back to back in one run of register transactions.
    task automatic apply_masks(input logic [3:0] echo_val, input logic [3:0] discard_val);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ECHO_MASK;
        cfg_data <= echo_val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_DISCARD_MASK;
        cfg_data <= discard_val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Send queued bytes in bursts of random length with random gaps between.
    task automatic send_stream(input int unsigned count);
        repeat (count) begin
            s_valid <= 1'b1;
            s_midi_byte <= midi_stream.pop_front();
            do @(posedge aclk); while (!s_ready);
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(16);
                if (!steady_send && $urandom_range(2) != 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(6, 1)) @(posedge aclk);
                end
            end
        end
        s_valid <= 1'b0;
    endtask

    // Block until every predicted byte has been accepted.
    task automatic wait_results();
        do @(posedge aclk); while (pending_count != 0);
    endtask

    // A framed channel message, optionally cut short before its last data byte.
    task automatic push_channel_msg(input bit truncate);
        logic [3:0]  kind;
        int unsigned n_data;
        case ($urandom_range(4))
            0: kind = HI_NOTE_OFF;
            1: kind = HI_NOTE_ON;
            2: kind = HI_CTRL_CHANGE;
            3: kind = HI_CHAN_PRESS;
            default: kind = HI_PITCH_BEND;
        endcase
        n_data = (kind == HI_CHAN_PRESS) ? 1 : 2;
        if (truncate) n_data = $urandom_range(n_data - 1);
        midi_stream.push_back({kind, 4'($urandom_range(15))});
        for (int i = 0; i < n_data; i++) begin
            if (i == 0 && kind == HI_CTRL_CHANGE && $urandom_range(1) == 1) begin
                midi_stream.push_back(CC_MOD_WHEEL);
            end else begin
                midi_stream.push_back(8'($urandom_range(127)));
            end
        end
    endtask

    task automatic push_sysex(input int unsigned n_data);
        midi_stream.push_back(ST_SYSEX_START);
        repeat (n_data) midi_stream.push_back(8'($urandom_range(127)));
        midi_stream.push_back(ST_SYSEX_END);
    endtask

    // Malformed traffic: cut messages, interrupted SysEx, running status, unframed status.
    task automatic push_broken();
        logic [7:0] status;
        case ($urandom_range(3))
            0: push_channel_msg(1'b1);
            1: begin
                midi_stream.push_back(ST_SYSEX_START);
                repeat ($urandom_range(5)) midi_stream.push_back(8'($urandom_range(127)));
                status = 8'($urandom_range(255, 128));
                if (status == ST_SYSEX_END) status = ST_SYSEX_START;
                midi_stream.push_back(status);
            end
            2: begin
                push_channel_msg(1'b0);
                repeat ($urandom_range(3, 1)) midi_stream.push_back(8'($urandom_range(127)));
            end
            default: begin
                status = {($urandom_range(1) == 1) ? HI_POLY_PRESS : HI_PROG_CHANGE,
                          4'($urandom_range(15))};
                midi_stream.push_back(status);
                midi_stream.push_back(8'($urandom_range(127)));
                midi_stream.push_back(ST_SYSEX_END);
            end
        endcase
    endtask

    // Mostly well-formed messages with random content, the rest broken or noise.
    task automatic build_random_stream(input int unsigned n_bytes);
        int unsigned target;
        int unsigned pick;
        target = midi_stream.size() + n_bytes;
        while (midi_stream.size() < target) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                push_channel_msg(1'b0);
            end else if (pick < 65) begin
                push_sysex($urandom_range(8));
            end else if (pick < 82) begin
                push_broken();
            end else begin
                midi_stream.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    // Main sequence: reset, opening sequence, then random phases under several masks.
    initial begin
        logic [3:0]  echo_set;
        logic [3:0]  discard_set;
        int unsigned half;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_midi_byte <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_ECHO_MASK;
        cfg_data <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        apply_masks(4'h0, 4'h0);
        foreach (opening_seq[i]) midi_stream.push_back(opening_seq[i]);
        send_stream(midi_stream.size());
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    echo_set = 4'hF;
                    discard_set = 4'hF;
                end
                1: begin
                    echo_set = 4'h0;
                    discard_set = 4'hF;
                end
                default: begin
                    echo_set = 4'($urandom_range(15));
                    discard_set = 4'($urandom_range(15));
                end
            endcase
            apply_masks(echo_set, discard_set);

            // Complete messages up front, so the hold-off phase surely stalls the input.
            if (p == 0) begin
                repeat (3) push_channel_msg(1'b0);
            end
            build_random_stream(RANDOM_BYTES);
            // SysEx that overflows the buffer on a data byte and is dropped at its end.
            if (p == 2) push_sysex(MIDI_BUF_DEPTH);
            half = midi_stream.size() / 2;

            // First phase: long receiver hold-off while bytes keep coming.
            if (p == 0) begin
                steady_send = 1'b1;
                hold_seq <= hold_seq + 1;
            end
            send_stream(half);
            steady_send = 1'b0;
            wait_results();
            send_stream(midi_stream.size());
            wait_results();
            repeat (SETTLE_CYCLES) @(posedge aclk);
        end

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/mmff_pkg.sv
src/mmff_datapath.sv
src/mmff_ctrl.sv
src/midi_message_framer_filter.sv
verif/mmff_stream_checker.sv
verif/tb_midi_message_framer_filter.sv
